[rtl/fqc_pkg.sv]
// Shared types, character codes and a count-clipping helper for the FASTQ record checker.
`default_nettype none

package fqc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FIELD_WIDTH = 16;

    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_AT     = 3'd1,
        ST_NO_PLUS   = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_TRUNCATED = 3'd4
    } fqc_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fqc_byte_t;

    typedef struct packed {
        fqc_status_t            status;
        logic [FIELD_WIDTH-1:0] sequence_count;
        logic [FIELD_WIDTH-1:0] quality_count;
    } fqc_result_t;

    // Clip an internal counter to the width of the result fields.
    function automatic logic [FIELD_WIDTH-1:0] clip_count(input logic [COUNT_WIDTH-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'({FIELD_WIDTH{1'b1}})) ? {FIELD_WIDTH{1'b1}} : w[FIELD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/fqc_byte_if.sv]
// Valid/ready channel carrying one byte of the FASTQ text stream.
`default_nettype none

interface fqc_byte_if;
    logic              valid;
    logic              ready;
    fqc_pkg::fqc_byte_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/fqc_result_if.sv]
// Valid/ready channel carrying one record status and its counts.
`default_nettype none

interface fqc_result_if;
    logic                valid;
    logic                ready;
    fqc_pkg::fqc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/fastq_record_checker_unit.sv]
// FASTQ record checker: top level with parser state and two-entry result buffer.
//
// Usage:
//   bytes   - sink channel, one text byte per request plus a last_byte mark.
//   results - source channel, one status per completed or failed record, with
//             the sequence and quality character counts (saturating).
// Throughput: one byte per cycle while the skid entry is free. The parser state
// is updated in the same cycle a byte is accepted; the byte-to-byte dependency
// is only the phase/counter update, which is a few gates and one counter increment.
// A result is registered: into the output register if free or being taken, else the skid.
// Results go to an output register backed by one skid register, so bytes keep
// flowing while a result waits. bytes.ready drops only when both entries hold
// results, and rises again as soon as the receiver takes one.
// Reset: the parser expects '@', all counters are zero, no drain is pending
// and both result entries are empty.
// Stall: a stalled result holds its value until taken; at most one further
// result is buffered behind it.
`default_nettype none

module fastq_record_checker_unit (
    input  wire          clk,
    input  wire          rst_n,
    fqc_byte_if.sink     bytes,
    fqc_result_if.source results
);
    import fqc_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_ID,
        PH_SEQ,
        PH_PLUS,
        PH_QUAL
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic                   absorb_reg, absorb_next;
    logic                   plus_chk_reg, plus_chk_next;
    logic [COUNT_WIDTH-1:0] seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] qual_reg, qual_next;
    logic                   drain_reg, drain_next;

    fqc_result_t out_reg;
    logic        out_valid_reg;
    fqc_result_t skid_reg;
    logic        skid_valid_reg;

    logic                   emit;
    fqc_status_t            emit_status;
    logic [COUNT_WIDTH-1:0] emit_seq;
    logic [COUNT_WIDTH-1:0] emit_qual;
    fqc_result_t            res;

    logic [7:0] c;
    logic       last;
    logic       term;
    logic       done;
    logic       fire;
    logic       out_take;

    assign c    = bytes.data.data_byte;
    assign last = bytes.data.last_byte;
    assign term = (c == CH_LF) || (c == CH_CR);

    assign bytes.ready   = !skid_valid_reg;
    assign fire          = bytes.valid && !skid_valid_reg;
    assign out_take      = out_valid_reg && results.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        absorb_next   = absorb_reg;
        plus_chk_next = plus_chk_reg;
        seq_next      = seq_reg;
        qual_next     = qual_reg;
        drain_next    = drain_reg;
        emit          = 1'b0;
        emit_status   = ST_OK;
        emit_seq      = seq_reg;
        emit_qual     = qual_reg;
        done          = 1'b0;

        if (drain_reg)
        begin
            if (last)
            begin
                drain_next = 1'b0;
            end
            done = 1'b1;
        end
        else
        begin
            if (absorb_reg)
            begin
                absorb_next = 1'b0;
                if (c == CH_LF)
                begin
                    done = 1'b1;
                    if (last)
                    begin
                        if (phase_reg != PH_START)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_TRUNCATED;
                        end
                        phase_next    = PH_START;
                        plus_chk_next = 1'b0;
                        seq_next      = '0;
                        qual_next     = '0;
                    end
                end
            end

            if (!done)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (c != CH_AT)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NO_AT;
                            emit_seq    = '0;
                            emit_qual   = '0;
                            seq_next    = '0;
                            qual_next   = '0;
                            drain_next  = !last;
                            done        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        if (term)
                        begin
                            phase_next  = PH_SEQ;
                            absorb_next = 1'b1;
                        end
                    end
                    PH_SEQ:
                    begin
                        if (term)
                        begin
                            phase_next    = PH_PLUS;
                            absorb_next   = 1'b1;
                            plus_chk_next = 1'b1;
                        end
                        else if (seq_reg != COUNT_MAX)
                        begin
                            seq_next = seq_reg + 1'b1;
                        end
                    end
                    PH_PLUS:
                    begin
                        if (plus_chk_reg)
                        begin
                            plus_chk_next = 1'b0;
                            if (c != CH_PLUS)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NO_PLUS;
                                phase_next  = PH_START;
                                absorb_next = 1'b0;
                                seq_next    = '0;
                                qual_next   = '0;
                                drain_next  = !last;
                                done        = 1'b1;
                            end
                        end
                        if (!done && term)
                        begin
                            phase_next  = PH_QUAL;
                            absorb_next = 1'b1;
                        end
                    end
                    PH_QUAL:
                    begin
                        if (term)
                        begin
                            emit          = 1'b1;
                            emit_status   = (seq_reg == qual_reg) ? ST_OK : ST_MISMATCH;
                            phase_next    = PH_START;
                            plus_chk_next = 1'b0;
                            seq_next      = '0;
                            qual_next     = '0;
                            drain_next    = (seq_reg != qual_reg) && !last;
                            absorb_next   = (seq_reg == qual_reg) && !last;
                            done          = 1'b1;
                        end
                        else if (qual_reg != COUNT_MAX)
                        begin
                            qual_next = qual_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end

            // End of buffer: a record still open is truncated.
            if (!done && last)
            begin
                if (phase_next != PH_START)
                begin
                    emit        = 1'b1;
                    emit_status = ST_TRUNCATED;
                    emit_seq    = seq_next;
                    emit_qual   = qual_next;
                end
                phase_next    = PH_START;
                absorb_next   = 1'b0;
                plus_chk_next = 1'b0;
                seq_next      = '0;
                qual_next     = '0;
            end
        end
    end

    assign res.status         = emit_status;
    assign res.sequence_count = clip_count(emit_seq);
    assign res.quality_count  = clip_count(emit_qual);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            absorb_reg     <= 1'b0;
            plus_chk_reg   <= 1'b0;
            seq_reg        <= '0;
            qual_reg       <= '0;
            drain_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg    <= phase_next;
                absorb_reg   <= absorb_next;
                plus_chk_reg <= plus_chk_next;
                seq_reg      <= seq_next;
                qual_reg     <= qual_next;
                drain_reg    <= drain_next;
            end

            if (skid_valid_reg)
            begin
                // no byte is accepted here, so only the buffered result moves
                if (out_take)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (fire && emit)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (phase_reg == PH_START) && (seq_reg == '0) && (qual_reg == '0))
        else $error("drain active with record state not restarted");

    a_plus_chk_phase: assert property (@(posedge clk) disable iff (!rst_n)
        plus_chk_reg |-> (phase_reg == PH_PLUS))
        else $error("plus check pending outside the plus line");

    a_ok_counts_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_OK))
            |-> (out_reg.sequence_count == out_reg.quality_count))
        else $error("ok status with unequal counts");

    a_stalled_result_buffered: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && out_valid_reg && !results.ready) |=> skid_valid_reg)
        else $error("result produced during a stall was not buffered");

endmodule

`default_nettype wire

[dv/fastq_record_checker_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the FASTQ record checker: directed and random byte streams.
module fastq_record_checker_unit_tb;
    import fqc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTED = 50;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [63:0] FIELD_MAX = (64'd1 << FIELD_WIDTH) - 64'd1;
    localparam logic [7:0] CARET = 8'h5E;

    typedef enum logic [2:0] {AWAIT_AT, IN_ID, IN_SEQ, IN_PLUS, IN_QUAL} rec_phase_t;

    logic clk;
    logic rst_n;

    fqc_byte_if   bytes_ch();
    fqc_result_if results_ch();

    fastq_record_checker_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    // Parser state as the checker sees it
    rec_phase_t  phase;
    logic        lf_skip;
    logic        plus_due;
    logic        draining;
    logic [63:0] seq_cnt;
    logic [63:0] qual_cnt;

    fqc_result_t pending_results[$];
    fqc_byte_t   rec_bytes[$];

    int fail_count = 0;
    int counted_items = 0;
    int cycle_count = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_gaps_on = 1'b0;
    logic rx_hold;
    int hold_len = 0;
    event hold_go;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [63:0] v);
        return (v > FIELD_MAX) ? FIELD_MAX[FIELD_WIDTH-1:0] : v[FIELD_WIDTH-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic clear_record();
        phase = AWAIT_AT;
        lf_skip = 1'b0;
        plus_due = 1'b0;
        seq_cnt = '0;
        qual_cnt = '0;
    endtask

    task automatic post_status(input fqc_status_t st, input logic last);
        fqc_result_t r;
        r.status = st;
        r.sequence_count = to_field(seq_cnt);
        r.quality_count = to_field(qual_cnt);
        pending_results.push_back(r);
        clear_record();
        draining = (st != ST_OK) && !last;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic term;
        term = (c == CH_LF) || (c == CH_CR);
        if (draining)
        begin
            if (last)
            begin
                clear_record();
                draining = 1'b0;
            end
            return;
        end
        // one LF right after a terminator is swallowed
        if (lf_skip)
        begin
            lf_skip = 1'b0;
            if (c == CH_LF)
            begin
                if (last && phase != AWAIT_AT)
                    post_status(ST_TRUNCATED, 1'b1);
                else if (last)
                    clear_record();
                return;
            end
        end
        case (phase)
            AWAIT_AT:
            begin
                if (c != CH_AT)
                begin
                    seq_cnt = '0;
                    qual_cnt = '0;
                    post_status(ST_NO_AT, last);
                    return;
                end
                phase = IN_ID;
            end
            IN_ID:
            begin
                if (term)
                begin
                    phase = IN_SEQ;
                    lf_skip = 1'b1;
                end
            end
            IN_SEQ:
            begin
                if (term)
                begin
                    phase = IN_PLUS;
                    lf_skip = 1'b1;
                    plus_due = 1'b1;
                end
                else if (seq_cnt < COUNT_MAX)
                    seq_cnt++;
            end
            IN_PLUS:
            begin
                if (plus_due)
                begin
                    plus_due = 1'b0;
                    if (c != CH_PLUS)
                    begin
                        post_status(ST_NO_PLUS, last);
                        return;
                    end
                end
                if (term)
                begin
                    phase = IN_QUAL;
                    lf_skip = 1'b1;
                end
            end
            default:
            begin
                if (term)
                begin
                    post_status((seq_cnt == qual_cnt) ? ST_OK : ST_MISMATCH, last);
                    if (!last && !draining)
                        lf_skip = 1'b1;
                    return;
                end
                if (qual_cnt < COUNT_MAX)
                    qual_cnt++;
            end
        endcase
        if (last)
        begin
            if (phase != AWAIT_AT)
                post_status(ST_TRUNCATED, 1'b1);
            else
                clear_record();
        end
    endtask

    // Offer one byte, hold it until taken, then update the prediction.
    task automatic send_byte(input logic [7:0] c, input logic last);
        fqc_byte_t item;
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte = c;
        item.last_byte = last;
        bytes_ch.valid <= 1'b1;
        bytes_ch.data <= item;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        if (!draining)
            counted_items++;
        predict_byte(c, last);
    endtask

    // caret stands for CR; mark_last tags the final byte
    task automatic send_text(input string s, input bit mark_last);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c == CARET)
                c = CH_CR;
            send_byte(c, mark_last && (i == s.len() - 1));
        end
    endtask

    task automatic push_byte(input logic [7:0] c);
        fqc_byte_t item;
        item.data_byte = c;
        item.last_byte = 1'b0;
        rec_bytes.push_back(item);
    endtask

    task automatic push_content(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_LF || c == CH_CR);
            push_byte(c);
        end
    endtask

    task automatic push_term();
        case ($urandom_range(0, 2))
            0: push_byte(CH_LF);
            1: push_byte(CH_CR);
            default:
            begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        endcase
    endtask

    task automatic build_record();
        int n_seq;
        int n_qual;
        rec_bytes.delete();
        push_byte(CH_AT);
        push_content($urandom_range(0, 6));
        push_term();
        n_seq = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
        push_content(n_seq);
        push_term();
        push_byte(CH_PLUS);
        push_content(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
        push_term();
        n_qual = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : n_seq;
        push_content(n_qual);
        push_term();
    endtask

    task automatic test_good_records();
        logic [7:0] ext [17];
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_text("@r1\nACGT\n+\nIIII\n", 1'b0);
        send_text("@r2^\nAC^\n+r2^\nII^\n", 1'b0);
        send_text("@^^+^^", 1'b0);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        ext = '{CH_AT, 8'hFF, 8'h00, CH_LF, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_LF,
                CH_PLUS, 8'hFF, CH_LF, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_LF};
        foreach (ext[i])
            send_byte(ext[i], i == 16);
        // end of buffer on the swallowed LF between records: no status
        send_text("@a\nC\n+\nI\n", 1'b0);
        send_text("\n", 1'b1);
    endtask

    task automatic test_missing_at();
        send_text("Z@a\nC\n+\nI\n", 1'b1);
        send_text("\n", 1'b1);
        send_text("X", 1'b1);
        send_text("@a\nC\n+\nI\n\n\n", 1'b0);
        send_text("qq", 1'b1);
    endtask

    task automatic test_missing_plus();
        send_text("@a\nCC\n-\nII\n", 1'b1);
        send_text("@a\nC\nx", 1'b1);
        send_text("@b\nG\n+\nI\n", 1'b0);
    endtask

    task automatic test_mismatch();
        send_text("@a\nCCC\n+\nII\n", 1'b0);
        send_text("@z", 1'b1);
        send_text("@a\nC\n+\nIII^", 1'b1);
    endtask

    task automatic test_truncated();
        send_text("@", 1'b1);
        send_text("@ab", 1'b1);
        send_text("@a\nCG", 1'b1);
        send_text("@a\nCG\n+x", 1'b1);
        send_text("@a\nCG\n+\nI", 1'b1);
        send_text("@a\nCG^\n", 1'b1);
    endtask

    // receiver stalls long while each buffer below yields a status
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_len = 400;
        -> hold_go;
        repeat (12)
            send_text("X", 1'b1);
        send_text("@p\nAC\n+\nII\n", 1'b1);
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int item_base;
        int kind;
        int pos;
        item_base = counted_items;
        while (counted_items - item_base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (kind < 80)
            begin
                build_record();
                if ($urandom_range(0, 3) == 0)
                    rec_bytes[rec_bytes.size() - 1].last_byte = 1'b1;
            end
            else if (kind < 92)
            begin
                build_record();
                pos = $urandom_range(0, rec_bytes.size() - 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    rec_bytes[pos].last_byte = 1'b1;
                    while (rec_bytes.size() > pos + 1)
                        void'(rec_bytes.pop_back());
                end
                else
                    rec_bytes[pos].data_byte = 8'($urandom_range(0, 255));
            end
            else
            begin
                rec_bytes.delete();
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)));
                rec_bytes[rec_bytes.size() - 1].last_byte = ($urandom_range(0, 2) == 0);
            end
            foreach (rec_bytes[i])
                send_byte(rec_bytes[i].data_byte, rec_bytes[i].last_byte);
            if (draining)
            begin
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // long receiver hold-off, counted here
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(hold_go);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (hold_len) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // result side: check each taken status, then pick next ready
    initial
    begin
        fqc_result_t got;
        fqc_result_t want;
        int stall_left;
        stall_left = 0;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_ch.valid && results_ch.ready)
            begin
                got = results_ch.data;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("status %0d with none pending", got.status));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                    if (got.sequence_count !== want.sequence_count)
                        report_mismatch($sformatf("sequence_count got %0d want %0d",
                                                  got.sequence_count, want.sequence_count));
                    if (got.quality_count !== want.quality_count)
                        report_mismatch($sformatf("quality_count got %0d want %0d",
                                                  got.quality_count, want.quality_count));
                end
            end
            if (rx_hold)
                results_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
                if (rx_gaps_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        bytes_ch.valid = 1'b0;
        bytes_ch.data = '0;
        clear_record();
        draining = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_records();
        test_missing_at();
        test_missing_plus();
        test_mismatch();
        test_truncated();
        test_backpressure();
        test_random();

        bytes_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[fastq_record_checker_unit.f]
rtl/fqc_pkg.sv
rtl/fqc_byte_if.sv
rtl/fqc_result_if.sv
rtl/fastq_record_checker_unit.sv
dv/fastq_record_checker_unit_tb.sv
